/* rtl/core/nnsb_pkg.sv */
package nnsb_pkg;

    localparam int COVER_W_DEF = 64;
    localparam int COVER_H_DEF = 64;
    localparam int SCREEN_W    = 640;
    localparam int SCREEN_H    = 480;

    localparam int POS_W   = 10;  // rectangle row / column counters
    localparam int SIZE_W  = 11;  // rectangle width / height
    localparam int DEST_W  = 12;  // signed rectangle origin
    localparam int COORD_W = 11;  // screen row / column
    localparam int PIX_W   = 16;  // RGB555 pixel
    localparam int Q_W     = 18;  // source quotient, holds pos * cover
    localparam int REM_W   = 10;  // source remainder, below size
    localparam int SQ_W    = 9;   // per-step quotient, up to cover size

    localparam int RECT_MAX   = 1024;
    localparam int RECT_RESET = 64;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        REG_DEST_X = 2'd0,
        REG_DEST_Y = 2'd1,
        REG_RECT_W = 2'd2,
        REG_RECT_H = 2'd3
    } reg_idx_t;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_DRAW = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        FR_RUN,
        FR_LAUNCH,
        FR_WAIT
    } front_state_t;

    typedef enum logic [1:0] {
        DIV_COL_STEP = 2'd0,
        DIV_COL_POS  = 2'd1,
        DIV_ROW_STEP = 2'd2,
        DIV_ROW_POS  = 2'd3
    } div_sel_t;

    // rectangle geometry as the front sees it, sizes already clamped
    typedef struct packed {
        logic [DEST_W-1:0] dest_x;
        logic [DEST_W-1:0] dest_y;
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
    } geom_t;

    // one queued command for the back end
    typedef struct packed {
        logic               is_draw;
        logic               on_screen;
        logic               last;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   pixel;
    } cmd_t;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > SIZE_W'(RECT_MAX))
            r = SIZE_W'(RECT_MAX);
        else
            r = v;
        return r;
    endfunction

endpackage

/* rtl/core/nnsb_ram.sv */
module nnsb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/nnsb_div.sv */
module nnsb_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [nnsb_pkg::Q_W-1:0]    dividend,
    input  logic [nnsb_pkg::SIZE_W-1:0] divisor,
    output logic                      done,
    output logic [nnsb_pkg::Q_W-1:0]    quotient,
    output logic [nnsb_pkg::SIZE_W-1:0] remainder
);
    import nnsb_pkg::*;

    localparam int CNT_W = $clog2(Q_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [Q_W-1:0]    quo_reg;
    logic [SIZE_W:0]   rem_reg;
    logic [SIZE_W-1:0] div_reg;

    logic [SIZE_W:0]   rem_sh;
    logic              ge;
    logic [SIZE_W:0]   rem_next;
    logic [Q_W-1:0]    quo_next;

    // one quotient bit a cycle: dividend bits shift out the top of quo_reg
    always_comb
    begin
        rem_sh   = {rem_reg[SIZE_W-1:0], quo_reg[Q_W-1]};
        ge       = rem_sh >= {1'b0, div_reg};
        rem_next = ge ? (rem_sh - {1'b0, div_reg}) : rem_sh;
        quo_next = {quo_reg[Q_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(Q_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[SIZE_W-1:0];

endmodule

/* rtl/core/nnsb_front.sv */
module nnsb_front #(
    parameter int COVER_W = 64,
    parameter int COVER_H = 64,
    parameter int ADDR_W  = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  nnsb_pkg::geom_t           geom,
    input  logic                      size_wr,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  logic                      op,
    input  logic [nnsb_pkg::PIX_W-1:0] load_pixel,
    input  logic                      q_full,
    output logic                      push,
    output nnsb_pkg::cmd_t            push_cmd,
    output logic [ADDR_W-1:0]         push_addr
);
    import nnsb_pkg::*;

    localparam int COL_IDX_W = (COVER_W > 1) ? $clog2(COVER_W) : 1;
    localparam int ROW_IDX_W = (COVER_H > 1) ? $clog2(COVER_H) : 1;
    localparam logic [SQ_W-1:0]  COL_SQ_RST = SQ_W'(COVER_W / RECT_RESET);
    localparam logic [REM_W-1:0] COL_SR_RST = REM_W'(COVER_W % RECT_RESET);
    localparam logic [SQ_W-1:0]  ROW_SQ_RST = SQ_W'(COVER_H / RECT_RESET);
    localparam logic [REM_W-1:0] ROW_SR_RST = REM_W'(COVER_H % RECT_RESET);
    localparam logic [ADDR_W-1:0] LOAD_LAST = ADDR_W'(COVER_W * COVER_H - 1);

    front_state_t      state_reg, state_next;
    div_sel_t          div_sel_reg, div_sel_next;
    logic [ADDR_W-1:0] load_ptr_reg;
    logic [POS_W-1:0]  col_reg, row_reg;
    logic [Q_W-1:0]    cq_reg, rq_reg;
    logic [REM_W-1:0]  cr_reg, rr_reg;
    logic [SQ_W-1:0]   col_sq_reg, row_sq_reg;
    logic [REM_W-1:0]  col_sr_reg, row_sr_reg;

    logic busy, div_start, res_take;
    logic accept, is_draw;

    logic [DEST_W:0]        dy, dx;
    logic                   on_screen;
    logic [ROW_IDX_W-1:0]   sy;
    logic [COL_IDX_W-1:0]   sx;
    logic [ADDR_W-1:0]      draw_addr;
    logic                   row_end, last_pos;
    logic [SIZE_W-1:0]      csum, rsum;
    logic                   cwrap, rwrap;
    logic [Q_W-1:0]         cq_step, rq_step;
    logic [REM_W-1:0]       cr_step, rr_step;

    logic                   div_is_col, div_is_step;
    logic [POS_W-1:0]       div_pos;
    logic [SQ_W-1:0]        div_cover;
    logic [POS_W+SQ_W-1:0]  div_prod;
    logic [Q_W-1:0]         div_n;
    logic [SIZE_W-1:0]      div_d;
    logic                   div_done;
    logic [Q_W-1:0]         div_quo;
    logic [SIZE_W-1:0]      div_rem;

    // next state: a size write restarts the source-step recompute
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FR_RUN:    state_next = FR_RUN;
            FR_LAUNCH: state_next = FR_WAIT;
            FR_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (div_sel_reg == DIV_ROW_POS) ? FR_RUN : FR_LAUNCH;
                end
            end
            default:   state_next = FR_RUN;
        endcase
        if (size_wr)
        begin
            state_next = FR_LAUNCH;
        end
    end

    always_comb
    begin
        busy      = 1'b1;
        div_start = 1'b0;
        res_take  = 1'b0;
        case (state_reg)
            FR_RUN:    busy = 1'b0;
            FR_LAUNCH: div_start = 1'b1;
            FR_WAIT:   res_take = div_done;
            default:   busy = 1'b1;
        endcase
    end

    always_comb
    begin
        div_sel_next = div_sel_reg;
        if (size_wr)
            div_sel_next = DIV_COL_STEP;
        else if (res_take && (div_sel_reg != DIV_ROW_POS))
            div_sel_next = div_sel_t'(div_sel_reg + 2'd1);
    end

    assign item_stall = busy || q_full;
    assign accept     = item_valid && !item_stall;
    assign is_draw    = (op == OP_DRAW);

    // screen position and visibility
    always_comb
    begin
        dy = {geom.dest_y[DEST_W-1], geom.dest_y} + {{(DEST_W+1-POS_W){1'b0}}, row_reg};
        dx = {geom.dest_x[DEST_W-1], geom.dest_x} + {{(DEST_W+1-POS_W){1'b0}}, col_reg};
        on_screen = !dy[DEST_W] && (dy[DEST_W-1:0] < DEST_W'(SCREEN_H))
                 && !dx[DEST_W] && (dx[DEST_W-1:0] < DEST_W'(SCREEN_W));
    end

    // source pixel, clamped to the cover edge
    always_comb
    begin
        sy = (rq_reg >= Q_W'(COVER_H)) ? ROW_IDX_W'(COVER_H - 1) : rq_reg[ROW_IDX_W-1:0];
        sx = (cq_reg >= Q_W'(COVER_W)) ? COL_IDX_W'(COVER_W - 1) : cq_reg[COL_IDX_W-1:0];
        draw_addr = ADDR_W'(sy) * ADDR_W'(COVER_W) + ADDR_W'(sx);
    end

    // raster stepping with remainder accumulators
    always_comb
    begin
        row_end  = ({1'b0, col_reg} + SIZE_W'(1)) >= geom.w;
        last_pos = row_end && (({1'b0, row_reg} + SIZE_W'(1)) >= geom.h);

        csum    = {1'b0, cr_reg} + {1'b0, col_sr_reg};
        cwrap   = csum >= geom.w;
        cq_step = cq_reg + Q_W'(col_sq_reg) + Q_W'(cwrap);
        cr_step = cwrap ? REM_W'(csum - geom.w) : csum[REM_W-1:0];

        rsum    = {1'b0, rr_reg} + {1'b0, row_sr_reg};
        rwrap   = rsum >= geom.h;
        rq_step = rq_reg + Q_W'(row_sq_reg) + Q_W'(rwrap);
        rr_step = rwrap ? REM_W'(rsum - geom.h) : rsum[REM_W-1:0];
    end

    // divider operands: step = cover / size, position = pos * cover / size
    always_comb
    begin
        div_is_col  = (div_sel_reg == DIV_COL_STEP) || (div_sel_reg == DIV_COL_POS);
        div_is_step = (div_sel_reg == DIV_COL_STEP) || (div_sel_reg == DIV_ROW_STEP);
        div_pos     = div_is_col ? col_reg : row_reg;
        div_cover   = div_is_col ? SQ_W'(COVER_W) : SQ_W'(COVER_H);
        div_prod    = div_pos * div_cover;
        div_n       = div_is_step ? Q_W'(div_cover) : div_prod[Q_W-1:0];
        div_d       = div_is_col ? geom.w : geom.h;
    end

    nnsb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_n),
        .divisor   (div_d),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= FR_RUN;
            div_sel_reg  <= DIV_COL_STEP;
            load_ptr_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            cq_reg       <= '0;
            cr_reg       <= '0;
            rq_reg       <= '0;
            rr_reg       <= '0;
            col_sq_reg   <= COL_SQ_RST;
            col_sr_reg   <= COL_SR_RST;
            row_sq_reg   <= ROW_SQ_RST;
            row_sr_reg   <= ROW_SR_RST;
        end
        else
        begin
            state_reg   <= state_next;
            div_sel_reg <= div_sel_next;
            if (accept && !is_draw)
            begin
                load_ptr_reg <= (load_ptr_reg == LOAD_LAST) ? '0 : load_ptr_reg + ADDR_W'(1);
            end
            if (accept && is_draw)
            begin
                if (last_pos)
                begin
                    col_reg <= '0;
                    row_reg <= '0;
                    cq_reg  <= '0;
                    cr_reg  <= '0;
                    rq_reg  <= '0;
                    rr_reg  <= '0;
                end
                else if (row_end)
                begin
                    col_reg <= '0;
                    cq_reg  <= '0;
                    cr_reg  <= '0;
                    row_reg <= row_reg + POS_W'(1);
                    rq_reg  <= rq_step;
                    rr_reg  <= rr_step;
                end
                else
                begin
                    col_reg <= col_reg + POS_W'(1);
                    cq_reg  <= cq_step;
                    cr_reg  <= cr_step;
                end
            end
            if (res_take)
            begin
                case (div_sel_reg)
                    DIV_COL_STEP:
                    begin
                        col_sq_reg <= div_quo[SQ_W-1:0];
                        col_sr_reg <= div_rem[REM_W-1:0];
                    end
                    DIV_COL_POS:
                    begin
                        cq_reg <= div_quo;
                        cr_reg <= div_rem[REM_W-1:0];
                    end
                    DIV_ROW_STEP:
                    begin
                        row_sq_reg <= div_quo[SQ_W-1:0];
                        row_sr_reg <= div_rem[REM_W-1:0];
                    end
                    DIV_ROW_POS:
                    begin
                        rq_reg <= div_quo;
                        rr_reg <= div_rem[REM_W-1:0];
                    end
                    default:
                    begin
                        rq_reg <= rq_reg;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        push               = accept;
        push_cmd.is_draw   = is_draw;
        push_cmd.on_screen = is_draw && on_screen;
        push_cmd.last      = is_draw && last_pos;
        push_cmd.row       = on_screen ? dy[COORD_W-1:0] : '0;
        push_cmd.col       = on_screen ? dx[COORD_W-1:0] : '0;
        push_cmd.pixel     = load_pixel;
        push_addr          = is_draw ? draw_addr : load_ptr_reg;
    end

endmodule

/* rtl/core/nnsb_queue.sv */
module nnsb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data  = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));

endmodule

/* rtl/core/nnsb_back.sv */
module nnsb_back #(
    parameter int ADDR_W = 12,
    parameter int DEPTH  = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  nnsb_pkg::cmd_t              q_cmd,
    input  logic [ADDR_W-1:0]           q_addr,
    output logic                        q_pop,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [nnsb_pkg::COORD_W-1:0] screen_row,
    output logic [nnsb_pkg::COORD_W-1:0] screen_col,
    output logic [nnsb_pkg::PIX_W-1:0]   color,
    output logic                        write_enable,
    output logic                        last
);
    import nnsb_pkg::*;

    logic               s1_valid_reg;
    cmd_t               s1_cmd_reg;
    logic               out_valid_reg;
    logic [COORD_W-1:0] out_row_reg, out_col_reg;
    logic [PIX_W-1:0]   out_color_reg;
    logic               out_we_reg, out_last_reg;

    logic               s1_adv;
    logic               ram_we, ram_re;
    logic [PIX_W-1:0]   ram_rdata;

    // a draw may enter the read stage only if that stage is empty or drains this
    // cycle; loads retire straight into the store
    always_comb
    begin
        s1_adv = s1_valid_reg && (!out_valid_reg || !result_stall);
        q_pop  = q_valid && (!q_cmd.is_draw || !s1_valid_reg || s1_adv);
        ram_we = q_pop && !q_cmd.is_draw;
        ram_re = q_pop && q_cmd.is_draw;
    end

    nnsb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (q_addr),
        .wdata (q_cmd.pixel),
        .re    (ram_re),
        .raddr (q_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ram_re)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            s1_cmd_reg <= q_cmd;
        end
        if (s1_adv)
        begin
            out_row_reg   <= s1_cmd_reg.row;
            out_col_reg   <= s1_cmd_reg.col;
            out_color_reg <= s1_cmd_reg.on_screen ? ram_rdata : '0;
            out_we_reg    <= s1_cmd_reg.on_screen;
            out_last_reg  <= s1_cmd_reg.last;
        end
    end

    assign result_valid = out_valid_reg;
    assign screen_row   = out_row_reg;
    assign screen_col   = out_col_reg;
    assign color        = out_color_reg;
    assign write_enable = out_we_reg;
    assign last         = out_last_reg;

endmodule

/* rtl/core/nearest_neighbor_scale_blit_top.sv */
// Nearest-neighbor scaling blitter.
// Item channel (item_valid / item_stall, op, load_pixel): op LOAD writes the
// next cover pixel in raster order, op DRAW steps one position of the
// destination rectangle. Loads give no result; every draw gives one result
// beat (screen_row, screen_col, color, write_enable, last) on the result
// channel (result_valid / result_stall).
// Throughput: one item per cycle while item_stall is low, set by the source
// stepping in the front and one cover-store access per cycle in the back.
// A write to rect_width or rect_height recomputes the source step and
// position with a shared divider, four divisions in turn: item_stall stays
// high until the last division is done.
// Reset: load pointer and draw position go to zero, size to 64 x 64, origin
// to 0,0; the cover store contents are undefined until loaded.
// When the receiver stalls, the result is held, the front keeps taking items
// until the two-entry command queue fills, then raises item_stall.
// Registers via APB at 0x0 dest_x, 0x4 dest_y, 0x8 rect_width, 0xC rect_height.
module nearest_neighbor_scale_blit_top #(
    parameter int COVER_W = nnsb_pkg::COVER_W_DEF,
    parameter int COVER_H = nnsb_pkg::COVER_H_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [nnsb_pkg::PADDR_W-1:0] paddr,
    input  logic [nnsb_pkg::PDATA_W-1:0] pwdata,
    output logic [nnsb_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic                         op,
    input  logic [nnsb_pkg::PIX_W-1:0]   load_pixel,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [nnsb_pkg::COORD_W-1:0] screen_row,
    output logic [nnsb_pkg::COORD_W-1:0] screen_col,
    output logic [nnsb_pkg::PIX_W-1:0]   color,
    output logic                         write_enable,
    output logic                         last
);
    import nnsb_pkg::*;

    localparam int STORE_DEPTH = COVER_W * COVER_H;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CMD_W       = $bits(cmd_t);
    localparam int QDATA_W     = CMD_W + ADDR_W;

    logic [DEST_W-1:0] dest_x_reg, dest_y_reg;
    logic [SIZE_W-1:0] rect_w_reg, rect_h_reg;
    logic              cfg_wr, size_wr;
    reg_idx_t          cfg_idx;
    geom_t             geom;

    logic              push, q_full, q_valid, q_pop;
    cmd_t              push_cmd, q_cmd;
    logic [ADDR_W-1:0] push_addr, q_addr;
    logic [QDATA_W-1:0] q_data;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign size_wr = cfg_wr && ((cfg_idx == REG_RECT_W) || (cfg_idx == REG_RECT_H));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_x_reg <= '0;
            dest_y_reg <= '0;
            rect_w_reg <= SIZE_W'(RECT_RESET);
            rect_h_reg <= SIZE_W'(RECT_RESET);
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_DEST_X: dest_x_reg <= pwdata[DEST_W-1:0];
                REG_DEST_Y: dest_y_reg <= pwdata[DEST_W-1:0];
                REG_RECT_W: rect_w_reg <= pwdata[SIZE_W-1:0];
                REG_RECT_H: rect_h_reg <= pwdata[SIZE_W-1:0];
                default:    dest_x_reg <= dest_x_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_DEST_X: prdata = PDATA_W'(dest_x_reg);
            REG_DEST_Y: prdata = PDATA_W'(dest_y_reg);
            REG_RECT_W: prdata = PDATA_W'(rect_w_reg);
            REG_RECT_H: prdata = PDATA_W'(rect_h_reg);
            default:    prdata = '0;
        endcase
    end

    always_comb
    begin
        geom.dest_x = dest_x_reg;
        geom.dest_y = dest_y_reg;
        geom.w      = eff_size(rect_w_reg);
        geom.h      = eff_size(rect_h_reg);
    end

    nnsb_front #(
        .COVER_W (COVER_W),
        .COVER_H (COVER_H),
        .ADDR_W  (ADDR_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .geom       (geom),
        .size_wr    (size_wr),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .op         (op),
        .load_pixel (load_pixel),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_addr  (push_addr)
    );

    nnsb_queue #(
        .WIDTH (QDATA_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_addr, push_cmd}),
        .pop       (q_pop),
        .pop_data  (q_data),
        .not_empty (q_valid),
        .full      (q_full)
    );

    assign q_addr = q_data[QDATA_W-1 -: ADDR_W];
    assign q_cmd  = cmd_t'(q_data[CMD_W-1:0]);

    nnsb_back #(
        .ADDR_W (ADDR_W),
        .DEPTH  (STORE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_addr       (q_addr),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .screen_row   (screen_row),
        .screen_col   (screen_col),
        .color        (color),
        .write_enable (write_enable),
        .last         (last)
    );

endmodule

/* rtl/core/nnsb_checker.sv */
module nnsb_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         result_valid,
    input logic                         result_stall,
    input logic [nnsb_pkg::COORD_W-1:0] screen_row,
    input logic [nnsb_pkg::COORD_W-1:0] screen_col,
    input logic [nnsb_pkg::PIX_W-1:0]   color,
    input logic                         write_enable,
    input logic                         last
);
    import nnsb_pkg::*;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(screen_row)
            && $stable(screen_col) && $stable(color) && $stable(write_enable)
            && $stable(last))
        else $error("stalled result beat changed");

    a_offscreen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !write_enable |-> (screen_row == '0) && (screen_col == '0)
            && (color == '0))
        else $error("off-screen beat carries nonzero fields");

    a_onscreen_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && write_enable |-> (screen_row < COORD_W'(SCREEN_H))
            && (screen_col < COORD_W'(SCREEN_W)))
        else $error("written position lies off the screen");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !result_valid)
        else $error("result beat offered during reset");

endmodule

bind nearest_neighbor_scale_blit_top nnsb_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .screen_row   (screen_row),
    .screen_col   (screen_col),
    .color        (color),
    .write_enable (write_enable),
    .last         (last)
);

/* tb/tb_nearest_neighbor_scale_blit_top.sv */
`timescale 1ns / 1ps

module tb_nearest_neighbor_scale_blit_top;

    import nnsb_pkg::*;

    localparam int COV_W      = COVER_W_DEF;
    localparam int COV_H      = COVER_H_DEF;
    localparam int HANG_LIMIT = 5000;

    typedef struct packed {
        op_t              kind;
        logic [PIX_W-1:0] pix;
    } blit_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   color;
        logic               we;
        logic               last;
    } blit_px_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b1;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [PADDR_W-1:0]  paddr        = '0;
    logic [PDATA_W-1:0]  pwdata       = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                item_valid   = 1'b0;
    logic                item_stall;
    logic                item_op      = 1'b0;
    logic [PIX_W-1:0]    load_pixel   = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [COORD_W-1:0]  screen_row;
    logic [COORD_W-1:0]  screen_col;
    logic [PIX_W-1:0]    color;
    logic                write_enable;
    logic                last;

    // predictor state
    logic [PIX_W-1:0]    cover_img [0:COV_W*COV_H-1];
    logic [11:0]         load_addr   = '0;
    logic [POS_W-1:0]    rect_row    = '0;
    logic [POS_W-1:0]    rect_col    = '0;
    logic [DEST_W-1:0]   org_x       = '0;
    logic [DEST_W-1:0]   org_y       = '0;
    logic [SIZE_W-1:0]   size_w_reg  = SIZE_W'(RECT_RESET);
    logic [SIZE_W-1:0]   size_h_reg  = SIZE_W'(RECT_RESET);

    blit_item_t          item_q[$];
    blit_px_t            px_expect_q[$];

    logic                jitter_on    = 1'b0;
    int                  send_gap     = 0;
    int                  stall_left   = 0;
    int                  quiet_cycles = 0;
    int                  fault_count  = 0;
    int                  load_count   = 0;
    int                  draw_count   = 0;
    int                  shown_count  = 0;
    int                  rect_ends    = 0;
    int                  reg_writes   = 0;

    nearest_neighbor_scale_blit_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .op           (item_op),
        .load_pixel   (load_pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .screen_row   (screen_row),
        .screen_col   (screen_col),
        .color        (color),
        .write_enable (write_enable),
        .last         (last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int clamp_size(input logic [SIZE_W-1:0] v);
        int s;
        s = int'(v);
        if (s == 0)
            s = 1;
        else if (s > RECT_MAX)
            s = RECT_MAX;
        return s;
    endfunction

    // advance the blitter by one beat; a draw also queues the pixel it must produce
    function automatic void advance_blit(input op_t kind, input logic [PIX_W-1:0] pix);
        int       w, h, dy, dx, sy, sx;
        logic     on_scr, row_end, rect_end;
        blit_px_t px;
        if (kind == OP_LOAD)
        begin
            cover_img[load_addr] = pix;
            load_addr = load_addr + 1'b1;
            load_count++;
            return;
        end
        w  = clamp_size(size_w_reg);
        h  = clamp_size(size_h_reg);
        dy = int'($signed(org_y)) + int'(rect_row);
        dx = int'($signed(org_x)) + int'(rect_col);
        on_scr = dy >= 0 && dy < SCREEN_H && dx >= 0 && dx < SCREEN_W;
        px = '0;
        if (on_scr)
        begin
            // source index saturates when a shrink leaves the counter past the new size
            sy = (int'(rect_row) * COV_H) / h;
            sx = (int'(rect_col) * COV_W) / w;
            if (sy >= COV_H)
                sy = COV_H - 1;
            if (sx >= COV_W)
                sx = COV_W - 1;
            px.row   = COORD_W'(dy);
            px.col   = COORD_W'(dx);
            px.color = cover_img[sy * COV_W + sx];
            px.we    = 1'b1;
            shown_count++;
        end
        row_end  = int'(rect_col) + 1 >= w;
        rect_end = row_end && (int'(rect_row) + 1 >= h);
        px.last  = rect_end;
        if (rect_end)
        begin
            rect_row = '0;
            rect_col = '0;
            rect_ends++;
        end
        else if (row_end)
        begin
            rect_col = '0;
            rect_row = rect_row + 1'b1;
        end
        else
        begin
            rect_col = rect_col + 1'b1;
        end
        draw_count++;
        px_expect_q.push_back(px);
    endfunction

    function automatic logic [DEST_W-1:0] pick_origin(input int span);
        int v;
        case ($urandom_range(0, 7))
            0:       v = -2048;
            1:       v = 2047;
            2, 3:    v = int'($urandom_range(0, 4095)) - 2048;
            default: v = int'($urandom_range(0, span + 40)) - 20;
        endcase
        return DEST_W'(v);
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int v;
        case ($urandom_range(0, 19))
            0:             v = 0;
            1:             v = RECT_MAX;
            2:             v = $urandom_range(RECT_MAX + 1, 2047);
            3:             v = $urandom_range(1, RECT_MAX);
            4, 5, 6, 7:    v = $urandom_range(13, 100);
            default:       v = $urandom_range(1, 12);
        endcase
        return SIZE_W'(v);
    endfunction

    task automatic queue_item(input op_t kind, input logic [PIX_W-1:0] pix);
        blit_item_t it;
        it.kind = kind;
        it.pix  = pix;
        item_q.push_back(it);
    endtask

    // wait until nothing is pending or in flight, then let the pipeline empty
    task automatic drain();
        @(negedge clk);
        while (item_q.size() != 0 || item_valid || px_expect_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [PDATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DEST_X: org_x      = data[DEST_W-1:0];
            REG_DEST_Y: org_y      = data[DEST_W-1:0];
            REG_RECT_W: size_w_reg = data[SIZE_W-1:0];
            REG_RECT_H: size_h_reg = data[SIZE_W-1:0];
            default:    ;
        endcase
        reg_writes++;
        // hold off while the size divider recomputes
        repeat (4) @(negedge clk);
        while (item_stall)
            @(negedge clk);
    endtask

    task automatic log_fault(input string why, input blit_px_t want, input blit_px_t got);
        fault_count++;
        if (fault_count <= 10)
        begin
            $display("%s: expected row %0d col %0d color %h we %b last %b",
                     why, want.row, want.col, want.color, want.we, want.last);
            $display("    got row %0d col %0d color %h we %b last %b",
                     got.row, got.col, got.color, got.we, got.last);
        end
    endtask

    always @(posedge clk)
    begin : item_drive
        blit_item_t nxt;
        logic       send;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
                advance_blit(op_t'(item_op), load_pixel);
            // hold a stalled beat as it is
            if (!(item_valid && item_stall))
            begin
                send = 1'b0;
                if (send_gap != 0)
                begin
                    send_gap = send_gap - 1;
                end
                else if (item_q.size() != 0)
                begin
                    if (jitter_on && $urandom_range(0, 9) == 0)
                    begin
                        send_gap = $urandom_range(1, 12);
                    end
                    else
                    begin
                        nxt        = item_q.pop_front();
                        send       = 1'b1;
                        item_op    <= nxt.kind;
                        load_pixel <= nxt.pix;
                    end
                end
                item_valid <= send;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        blit_px_t got;
        blit_px_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                got = {screen_row, screen_col, color, write_enable, last};
                if (px_expect_q.size() == 0)
                begin
                    log_fault("unexpected beat", '0, got);
                end
                else
                begin
                    want = px_expect_q.pop_front();
                    if (got.row !== want.row || got.col !== want.col
                        || got.color !== want.color || got.we !== want.we
                        || got.last !== want.last)
                        log_fault("mismatch", want, got);
                end
            end
            if (stall_left != 0)
                stall_left = stall_left - 1;
            else if (jitter_on && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 12);
            result_stall <= (stall_left != 0);
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((item_valid && !item_stall) || (result_valid && !result_stall) || psel
            || !rst_n)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("watchdog: no beat moved for %0d cycles", HANG_LIMIT);
                $display("tb_nearest_neighbor_scale_blit_top: errors");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int n;
        int k;
        int rand_items;
        // drive a real falling edge so the asynchronous reset takes effect at once
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // fill the whole cover so no draw can touch an unloaded entry
        jitter_on = 1'b1;
        queue_item(OP_LOAD, '0);
        queue_item(OP_LOAD, '1);
        for (k = 2; k < COV_W * COV_H; k++)
            queue_item(OP_LOAD, PIX_W'($urandom));
        drain();

        // zero size on both axes at the far corners: 1 x 1, off screen
        apb_write(REG_DEST_X, 32'h800);
        apb_write(REG_DEST_Y, 32'h7FF);
        apb_write(REG_RECT_W, 32'h0);
        apb_write(REG_RECT_H, 32'h0);
        queue_item(OP_DRAW, '1);
        queue_item(OP_DRAW, '0);
        drain();

        // oversize width, origin at the bottom right pixel of the screen
        apb_write(REG_DEST_X, 32'd639);
        apb_write(REG_DEST_Y, 32'd479);
        apb_write(REG_RECT_W, 32'h7FF);
        apb_write(REG_RECT_H, 32'd1);
        for (k = 0; k < 3; k++)
            queue_item(OP_DRAW, PIX_W'($urandom));
        drain();

        // shrink mid-row: column counter past the new width ends the row
        apb_write(REG_DEST_X, 32'h0);
        apb_write(REG_DEST_Y, 32'h0);
        apb_write(REG_RECT_W, 32'd2);
        apb_write(REG_RECT_H, 32'd2);
        for (k = 0; k < 4; k++)
            queue_item(OP_DRAW, PIX_W'($urandom));
        // load pointer has wrapped: overwrite the first two entries
        queue_item(OP_LOAD, '1);
        queue_item(OP_LOAD, '0);
        queue_item(OP_DRAW, PIX_W'($urandom));
        queue_item(OP_DRAW, PIX_W'($urandom));

        rand_items = 0;
        while (rand_items < 1450)
        begin
            drain();
            jitter_on = (rand_items < 1250) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1))
                apb_write(REG_DEST_X, 32'(pick_origin(SCREEN_W)));
            if ($urandom_range(0, 1))
                apb_write(REG_DEST_Y, 32'(pick_origin(SCREEN_H)));
            if ($urandom_range(0, 1))
                apb_write(REG_RECT_W, 32'(pick_size()));
            if ($urandom_range(0, 1))
                apb_write(REG_RECT_H, 32'(pick_size()));
            n = $urandom_range(10, 120);
            for (k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 6) == 0)
                    queue_item(OP_LOAD, PIX_W'($urandom));
                else
                    queue_item(OP_DRAW, PIX_W'($urandom));
            end
            rand_items += n;
        end
        drain();
        repeat (6) @(negedge clk);

        if (px_expect_q.size() != 0)
        begin
            $display("%0d expected beats never arrived", px_expect_q.size());
            fault_count += px_expect_q.size();
        end
        $display("run covered %0d draw beats (%0d on screen, %0d rectangle ends), %0d loads",
                 draw_count, shown_count, rect_ends, load_count);
        $display("across %0d register writes; %0d faults", reg_writes, fault_count);
        if (fault_count == 0)
            $display("tb_nearest_neighbor_scale_blit_top: clean");
        else
            $display("tb_nearest_neighbor_scale_blit_top: errors");
        $finish;
    end

endmodule

/* files.f */
rtl/core/nnsb_pkg.sv
rtl/core/nnsb_ram.sv
rtl/core/nnsb_div.sv
rtl/core/nnsb_front.sv
rtl/core/nnsb_queue.sv
rtl/core/nnsb_back.sv
rtl/core/nearest_neighbor_scale_blit_top.sv
rtl/core/nnsb_checker.sv
tb/tb_nearest_neighbor_scale_blit_top.sv
